// ----- hdl/tsiw_pkg.sv -----
`default_nettype none

package tsiw_pkg;

  localparam int unsigned MaxLevel = 4;
  localparam int unsigned LevelW   = 3;
  localparam int unsigned CoordW   = 5;
  localparam int unsigned IndexW   = 10;
  localparam int unsigned SumW     = CoordW + 2;
  localparam int unsigned CalcW    = IndexW + 1;
  localparam int unsigned SelW     = 3;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned OutUserW = 2;

  typedef enum logic [SelW-1:0] {
    TET_CORNER   = 3'd0,
    TET_K_J_A    = 3'd1,
    TET_K_J_B    = 3'd2,
    TET_J_I      = 3'd3,
    TET_I_KJ     = 3'd4,
    TET_OPPOSITE = 3'd5
  } tet_sel_e;

  typedef struct packed {
    logic [IndexW-1:0] a;
    logic [IndexW-1:0] b;
    logic [IndexW-1:0] c;
    logic [IndexW-1:0] d;
  } tet_t;

endpackage

`default_nettype wire

// ----- hdl/tetra_subdivision_index_walker_top.sv -----
// Walks the lattice points (i,j,k), i+j+k <= r with r = 2^level (level saturates at 4),
// i outermost, k innermost. A request with restart set returns the walk to the origin and
// gives no result; otherwise it visits the current point and gives 6 tetrahedra inside,
// 5 when i+j+k = r-2, 1 when i+j+k = r-1, and one result with tet_valid low on the far face.
// tlast marks the last result of a point. A request is taken while the block is empty or in
// the cycle the previous request's last result moves to the output register, so an advance
// holds off the next request until all its results have moved on; a restart does not.
// The single result channel sets that pace. Writing level also returns the walk to the
// origin; write it only while the block is idle.
`default_nettype none

module tetra_subdivision_index_walker_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_wen_i,
  input  wire logic [tsiw_pkg::LevelW-1:0]   cfg_wdata_i,    // level
  input  wire logic                          s_axis_tvalid_i,
  output      logic                          s_axis_tready_o,
  input  wire logic [tsiw_pkg::InDataW-1:0]  s_axis_tdata_i, // restart
  output      logic                          m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // pt_i, pt_j, pt_k, point_index, vert_a, vert_b, vert_c, vert_d
  output      logic [tsiw_pkg::OutDataW-1:0] m_axis_tdata_o,
  output      logic [tsiw_pkg::OutUserW-1:0] m_axis_tuser_o, // tet_valid, last_of_walk
  output      logic                          m_axis_tlast_o
);

  localparam int unsigned CW = tsiw_pkg::CoordW;
  localparam int unsigned IW = tsiw_pkg::IndexW;
  localparam int unsigned SW = tsiw_pkg::SumW;
  localparam int unsigned AW = tsiw_pkg::CalcW;
  localparam int unsigned LW = tsiw_pkg::LevelW;
  localparam int unsigned XW = tsiw_pkg::SelW;

  logic [LW-1:0] level_q;
  logic [CW-1:0] cur_i_q, cur_i_d, cur_j_q, cur_j_d, cur_k_q, cur_k_d;
  logic [IW-1:0] cur_p_q, cur_p_d;

  logic          hold_vld_q, hold_vld_d;
  logic [XW-1:0] sel_q, sel_d;
  logic [XW-1:0] last_sel_q;
  logic          far_q, wend_q;
  logic [CW-1:0] hi_q, hj_q, hk_q;
  logic [IW-1:0] hp_q, vk_q, vj_q, vi_q, vkj_q, vij_q, vki_q, vkij_q;

  logic          out_vld_q;
  logic [tsiw_pkg::OutDataW-1:0] out_data_q;
  logic [tsiw_pkg::OutUserW-1:0] out_user_q;
  logic          out_last_q;

  logic [LW-1:0] lvl_sat;
  logic [CW-1:0] r;
  logic [SW-1:0] s, sum, sum1, sum2, sum_ij;
  logic [SW-1:0] s_i, s1_i;
  logic [AW-1:0] tri_n;
  logic [AW-1:0] p_x, vk_x, vj_x, vi_x, vij_x;
  logic [XW-1:0] last_sel;
  logic          far, wend;

  logic          out_free, move, last_move, take, advance;
  tsiw_pkg::tet_t tet;
  logic          tet_vld;

  assign lvl_sat = (level_q > LW'(tsiw_pkg::MaxLevel)) ? LW'(tsiw_pkg::MaxLevel) : level_q;
  assign r       = CW'(1) << lvl_sat;
  assign s       = SW'(r) + SW'(1);
  assign sum     = SW'(cur_i_q) + SW'(cur_j_q) + SW'(cur_k_q);
  assign sum1    = sum + SW'(1);
  assign sum2    = sum + SW'(2);
  assign sum_ij  = SW'(cur_i_q) + SW'(cur_j_q);
  assign far     = sum >= SW'(r);
  assign wend    = cur_i_q == r;

  assign s_i     = s - SW'(cur_i_q);
  assign s1_i    = s_i + SW'(1);
  assign tri_n   = AW'((AW'(s_i) * AW'(s1_i)) >> 1);

  assign p_x     = AW'(cur_p_q);
  assign vk_x    = p_x + AW'(1);
  assign vj_x    = p_x + AW'(s) - AW'(sum_ij);
  assign vi_x    = p_x + tri_n - AW'(cur_j_q);
  assign vij_x   = vi_x + AW'(r) - AW'(sum_ij);

  always_comb begin
    if (far || sum1 == SW'(r)) begin
      last_sel = XW'(tsiw_pkg::TET_CORNER);
    end else if (sum2 == SW'(r)) begin
      last_sel = XW'(tsiw_pkg::TET_I_KJ);
    end else begin
      last_sel = XW'(tsiw_pkg::TET_OPPOSITE);
    end
  end

  assign out_free  = !out_vld_q || m_axis_tready_i;
  assign move      = hold_vld_q && out_free;
  assign last_move = move && (sel_q == last_sel_q);
  assign s_axis_tready_o = !hold_vld_q || last_move;
  assign take      = s_axis_tvalid_i && s_axis_tready_o;
  assign advance   = take && !s_axis_tdata_i[0];

  always_comb begin
    cur_i_d = cur_i_q;
    cur_j_d = cur_j_q;
    cur_k_d = cur_k_q;
    cur_p_d = cur_p_q;
    if (take && s_axis_tdata_i[0]) begin
      cur_i_d = '0;
      cur_j_d = '0;
      cur_k_d = '0;
      cur_p_d = '0;
    end else if (advance) begin
      cur_p_d = cur_p_q + IW'(1);
      if (!far) begin
        cur_k_d = cur_k_q + CW'(1);
      end else if (sum_ij < SW'(r)) begin
        cur_j_d = cur_j_q + CW'(1);
        cur_k_d = '0;
      end else if (cur_i_q < r) begin
        cur_i_d = cur_i_q + CW'(1);
        cur_j_d = '0;
        cur_k_d = '0;
      end else begin
        cur_i_d = '0;
        cur_j_d = '0;
        cur_k_d = '0;
        cur_p_d = '0;
      end
    end
  end

  always_comb begin
    hold_vld_d = hold_vld_q;
    sel_d      = sel_q;
    if (advance) begin
      hold_vld_d = 1'b1;
      sel_d      = '0;
    end else if (last_move) begin
      hold_vld_d = 1'b0;
    end else if (move) begin
      sel_d = sel_q + XW'(1);
    end
  end

  always_comb begin
    tet = '0;
    unique case (tsiw_pkg::tet_sel_e'(sel_q))
      tsiw_pkg::TET_CORNER:   tet = '{hp_q,  vk_q,  vj_q,  vi_q};
      tsiw_pkg::TET_K_J_A:    tet = '{vk_q,  vkj_q, vj_q,  vi_q};
      tsiw_pkg::TET_K_J_B:    tet = '{vk_q,  vkj_q, vki_q, vi_q};
      tsiw_pkg::TET_J_I:      tet = '{vj_q,  vi_q,  vkj_q, vij_q};
      tsiw_pkg::TET_I_KJ:     tet = '{vi_q,  vkj_q, vij_q, vki_q};
      tsiw_pkg::TET_OPPOSITE: tet = '{vkj_q, vij_q, vki_q, vkij_q};
      default:                tet = '0;
    endcase
    if (far_q) begin
      tet = '0;
    end
  end
  assign tet_vld = !far_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= '0;
      cur_i_q    <= '0;
      cur_j_q    <= '0;
      cur_k_q    <= '0;
      cur_p_q    <= '0;
      hold_vld_q <= 1'b0;
      sel_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_wen_i) begin
        level_q <= cfg_wdata_i;
        cur_i_q <= '0;
        cur_j_q <= '0;
        cur_k_q <= '0;
        cur_p_q <= '0;
      end else begin
        cur_i_q <= cur_i_d;
        cur_j_q <= cur_j_d;
        cur_k_q <= cur_k_d;
        cur_p_q <= cur_p_d;
      end
      hold_vld_q <= hold_vld_d;
      sel_q      <= sel_d;
      if (out_free) begin
        out_vld_q <= hold_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      last_sel_q <= last_sel;
      far_q      <= far;
      wend_q     <= wend;
      hi_q       <= cur_i_q;
      hj_q       <= cur_j_q;
      hk_q       <= cur_k_q;
      hp_q       <= cur_p_q;
      vk_q       <= IW'(vk_x);
      vj_q       <= IW'(vj_x);
      vi_q       <= IW'(vi_x);
      vkj_q      <= IW'(vj_x + AW'(1));
      vij_q      <= IW'(vij_x);
      vki_q      <= IW'(vi_x + AW'(1));
      vkij_q     <= IW'(vij_x + AW'(1));
    end
    if (move) begin
      out_data_q <= {7'd0, tet.d, tet.c, tet.b, tet.a, hp_q, hk_q, hj_q, hi_q};
      out_user_q <= {wend_q, tet_vld};
      out_last_q <= sel_q == last_sel_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire
